// ===== src/aac_pkg.sv =====
// Shared constants, codes and elaboration-time exponential helpers for the acceptance controller.
`timescale 1ns / 1ps
package aac_pkg;

  // field widths
  localparam int unsigned ENERGY_W = 32;
  localparam int unsigned RAND_W   = 16;
  localparam int unsigned TEMP_W   = 32;
  localparam int unsigned STEP_W   = 40;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned CALL_W   = 24;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned GROW_W   = 18;
  localparam int unsigned FLOOR_W  = 32;
  localparam int unsigned CODE_W   = 2;

  // stream and register port widths
  localparam int unsigned S_DATA_W = 48;
  localparam int unsigned M_DATA_W = 80;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned REG_IDX_W = 3;

  // serial divider: quotient bits, dividend width
  localparam int unsigned Q_W        = 12;
  localparam int unsigned NUM_W      = ENERGY_W + 8;
  localparam int unsigned DIV_CNT_W  = $clog2(Q_W);

  // serial multiplier operand width (Q0.60 values up to 1.0)
  localparam int unsigned MUL_W      = 61;
  localparam int unsigned MUL_CNT_W  = $clog2(MUL_W);

  localparam logic [Q_W-1:0] Q_SAT = '1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_TPR     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_LOW     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_HIGH    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHRINK  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GROW    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_COOLING = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT   = 3'd7;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_TRIAL = 1'b1;

  // step change codes
  localparam logic [CODE_W-1:0] CHG_NONE   = 2'd0;
  localparam logic [CODE_W-1:0] CHG_SHRINK = 2'd1;
  localparam logic [CODE_W-1:0] CHG_GROW   = 2'd2;

  // run result codes
  localparam logic [CODE_W-1:0] HALT_RUN  = 2'd0;
  localparam logic [CODE_W-1:0] HALT_CONV = 2'd1;
  localparam logic [CODE_W-1:0] HALT_FAIL = 2'd2;

  // reset values
  localparam logic [CNT_W-1:0]   TPR_RST     = 10'd100;
  localparam logic [CNT_W-1:0]   LOW_RST     = 10'd40;
  localparam logic [CNT_W-1:0]   HIGH_RST    = 10'd60;
  localparam logic [FRAC_W-1:0]  SHRINK_RST  = 16'd62259;
  localparam logic [GROW_W-1:0]  GROW_RST    = 18'd68985;
  localparam logic [FRAC_W-1:0]  COOLING_RST = 16'd62259;
  localparam logic [FLOOR_W-1:0] FLOOR_RST   = 32'd429;
  localparam logic [CALL_W-1:0]  LIMIT_RST   = 24'd10000000;
  localparam logic [TEMP_W-1:0]  TEMP_RST    = 32'd65536;
  localparam logic [STEP_W-1:0]  STEP_RST    = 40'd429496730;
  localparam logic [CALL_W-1:0]  CALL_MAX    = '1;

  localparam logic [63:0] ONE_Q60 = 64'd1 << 60;

  // (a*b) >> 60, exact
  function automatic logic [63:0] mul_q60_f(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // n / k by shift and subtract
  function automatic logic [63:0] div_small_f(input logic [63:0] n, input logic [5:0] k);
    logic [63:0] r;
    logic [63:0] qt;
    r  = '0;
    qt = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= {58'd0, k}) begin
        r     = r - {58'd0, k};
        qt[i] = 1'b1;
      end
    end
    return qt;
  endfunction

  // exp(-x), x and result in Q0.60, forty series terms
  function automatic logic [63:0] exp_neg_f(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = ONE_Q60;
    term = ONE_Q60;
    for (int k = 1; k <= 40; k++) begin
      term = div_small_f(mul_q60_f(term, x), 6'(k));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    return sum;
  endfunction

  // exp(-n) in Q0.60 as a chain of truncated products
  function automatic logic [63:0] exp_int_f(input int n);
    logic [63:0] v;
    logic [63:0] e1;
    v  = ONE_Q60;
    e1 = exp_neg_f(ONE_Q60);
    for (int i = 0; i < n; i++) begin
      v = mul_q60_f(v, e1);
    end
    return v;
  endfunction

endpackage

// ===== src/annealing_acceptance_controller.sv =====
// Top level: register port, trial sequencer, serial divider and multiplier, output register.
// A load, or any request once halted, passes straight from idle to the output state.
// A trial whose energy falls skips to the update; else it runs the serial divider, unless
// the quotient saturates, and the bit-serial 61-bit multiplier; round ends add a multiply.
// One request is in work at a time; a finished result waits in the output register.
// Asynchronous active-low reset restores all registers but the payload and output data.
`timescale 1ns / 1ps
module annealing_acceptance_controller (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // energy_in[31:0], rand_u[47:32]
  input  logic [aac_pkg::S_DATA_W-1:0]   s_tdata,
  // req_type[0]
  input  logic                           s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // accepted[0], round_done[1], step_change[3:2], run_result[5:4],
  // step_now[45:6], temp_now[77:46], zero[79:78]
  output logic [aac_pkg::M_DATA_W-1:0]   m_tdata,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [aac_pkg::APB_AW-1:0]     paddr,
  input  logic [aac_pkg::APB_DW-1:0]     pwdata,
  output logic [aac_pkg::APB_DW-1:0]     prdata,
  output logic                           pready
);

  localparam int unsigned W = aac_pkg::MUL_W;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_DELTA = 7'b0000010,
    ST_DIV   = 7'b0000100,
    ST_EXP   = 7'b0001000,
    ST_UPD   = 7'b0010000,
    ST_ADJ   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_e;

  state_e state_q;

  // configuration
  logic [aac_pkg::CNT_W-1:0]   tpr_q;
  logic [aac_pkg::CNT_W-1:0]   low_q;
  logic [aac_pkg::CNT_W-1:0]   high_q;
  logic [aac_pkg::FRAC_W-1:0]  shrink_q;
  logic [aac_pkg::GROW_W-1:0]  grow_q;
  logic [aac_pkg::FRAC_W-1:0]  cooling_q;
  logic [aac_pkg::FLOOR_W-1:0] floor_q;
  logic [aac_pkg::CALL_W-1:0]  limit_q;

  // annealing state
  logic [aac_pkg::ENERGY_W-1:0] cur_q;
  logic [aac_pkg::TEMP_W-1:0]   temp_q;
  logic [aac_pkg::STEP_W-1:0]   step_q;
  logic [aac_pkg::CNT_W-1:0]    trial_q;
  logic [aac_pkg::CNT_W-1:0]    succ_q;
  logic [aac_pkg::CALL_W-1:0]   call_q;
  logic [aac_pkg::CODE_W-1:0]   halt_q;

  // per-request flags
  logic                         acc_q;
  logic                         done_q;
  logic [aac_pkg::CODE_W-1:0]   change_q;
  logic                         conv_q;
  logic                         m_tvalid_q;

  // payload
  logic [aac_pkg::ENERGY_W-1:0] energy_q;
  logic [aac_pkg::RAND_W-1:0]   rand_q;
  logic [aac_pkg::M_DATA_W-1:0] m_tdata_q;

  logic                         wr_en;
  logic [aac_pkg::REG_IDX_W-1:0] reg_idx;

  logic [aac_pkg::ENERGY_W:0]   delta;
  logic [aac_pkg::NUM_W-1:0]    num;
  logic                         q_sat;
  logic                         div_start;
  logic                         div_done;
  logic [aac_pkg::Q_W-1:0]      div_quot;
  logic [aac_pkg::Q_W-1:0]      q_sel;

  logic                         mul_start;
  logic                         mul_done;
  logic [W-1:0]                 mul_a;
  logic [W-1:0]                 mul_b;
  logic [2*W-1:0]               prod;

  logic [W:0]                   thr_sum;
  logic [17:0]                  thr_raw;
  logic [aac_pkg::RAND_W-1:0]   thr;
  logic                         exp_acc;

  logic [aac_pkg::CNT_W-1:0]    trial_nx;
  logic [aac_pkg::CNT_W-1:0]    succ_nx;
  logic                         round_end;
  logic [aac_pkg::CODE_W-1:0]   change_nx;
  logic [aac_pkg::STEP_W+1:0]   grown;
  logic                         out_free;
  logic                         out_load;

  logic [W-1:0] exp_int_tab  [16];
  logic [W-1:0] exp_frac_tab [256];

  for (genvar g = 0; g < 16; g++) begin : g_exp_int
    localparam logic [63:0] EV = aac_pkg::exp_int_f(g);
    assign exp_int_tab[g] = EV[W-1:0];
  end

  for (genvar g = 0; g < 256; g++) begin : g_exp_frac
    localparam logic [63:0] FV = aac_pkg::exp_neg_f(64'(g) << 52);
    assign exp_frac_tab[g] = FV[W-1:0];
  end

  // register port
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[aac_pkg::APB_AW-1:2];

  always_comb begin
    case (reg_idx)
      aac_pkg::REG_TPR:     prdata = aac_pkg::APB_DW'(tpr_q);
      aac_pkg::REG_LOW:     prdata = aac_pkg::APB_DW'(low_q);
      aac_pkg::REG_HIGH:    prdata = aac_pkg::APB_DW'(high_q);
      aac_pkg::REG_SHRINK:  prdata = aac_pkg::APB_DW'(shrink_q);
      aac_pkg::REG_GROW:    prdata = aac_pkg::APB_DW'(grow_q);
      aac_pkg::REG_COOLING: prdata = aac_pkg::APB_DW'(cooling_q);
      aac_pkg::REG_FLOOR:   prdata = aac_pkg::APB_DW'(floor_q);
      aac_pkg::REG_LIMIT:   prdata = aac_pkg::APB_DW'(limit_q);
      default:              prdata = '0;
    endcase
  end

  // acceptance datapath
  assign delta = {energy_q[aac_pkg::ENERGY_W-1], energy_q} - {cur_q[aac_pkg::ENERGY_W-1], cur_q};
  assign num   = {delta[aac_pkg::ENERGY_W-1:0], 8'd0};
  assign q_sat = {4'd0, num} >= {temp_q, 12'd0};

  assign div_start = (state_q == ST_DELTA) && !delta[aac_pkg::ENERGY_W] && !q_sat;
  assign q_sel     = (state_q == ST_DELTA) ? aac_pkg::Q_SAT : div_quot;

  aac_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (temp_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign thr_sum = prod[2*W-1:60] + ((W+1)'(1) << 43);
  assign thr_raw = thr_sum[61:44];
  assign thr     = (thr_raw > 18'd65535) ? '1 : thr_raw[aac_pkg::RAND_W-1:0];
  assign exp_acc = rand_q < thr;

  // round bookkeeping
  assign trial_nx  = trial_q + 1'b1;
  assign succ_nx   = succ_q + aac_pkg::CNT_W'(acc_q);
  assign round_end = trial_nx >= tpr_q;

  always_comb begin
    if (succ_nx < low_q) begin
      change_nx = aac_pkg::CHG_SHRINK;
    end else if (succ_nx > high_q) begin
      change_nx = aac_pkg::CHG_GROW;
    end else begin
      change_nx = aac_pkg::CHG_NONE;
    end
  end

  always_comb begin
    mul_start = 1'b0;
    mul_a     = exp_int_tab[q_sel[11:8]];
    mul_b     = exp_frac_tab[q_sel[7:0]];
    case (state_q)
      ST_DELTA: mul_start = !delta[aac_pkg::ENERGY_W] && q_sat;
      ST_DIV:   mul_start = div_done;
      ST_UPD: begin
        mul_start = round_end;
        case (change_nx)
          aac_pkg::CHG_SHRINK: begin
            mul_a = W'(step_q);
            mul_b = W'(shrink_q);
          end
          aac_pkg::CHG_GROW: begin
            mul_a = W'(step_q);
            mul_b = W'(grow_q);
          end
          default: begin
            mul_a = W'(temp_q);
            mul_b = W'(cooling_q);
          end
        endcase
      end
      default: mul_start = 1'b0;
    endcase
  end

  aac_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .prod_o  (prod)
  );

  assign grown    = prod[aac_pkg::STEP_W+17:16];
  assign out_free = !m_tvalid_q || m_tready;
  assign out_load = (state_q == ST_OUT) && out_free;

  // sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      tpr_q      <= aac_pkg::TPR_RST;
      low_q      <= aac_pkg::LOW_RST;
      high_q     <= aac_pkg::HIGH_RST;
      shrink_q   <= aac_pkg::SHRINK_RST;
      grow_q     <= aac_pkg::GROW_RST;
      cooling_q  <= aac_pkg::COOLING_RST;
      floor_q    <= aac_pkg::FLOOR_RST;
      limit_q    <= aac_pkg::LIMIT_RST;
      cur_q      <= '0;
      temp_q     <= aac_pkg::TEMP_RST;
      step_q     <= aac_pkg::STEP_RST;
      trial_q    <= '0;
      succ_q     <= '0;
      call_q     <= '0;
      halt_q     <= aac_pkg::HALT_RUN;
      acc_q      <= 1'b0;
      done_q     <= 1'b0;
      change_q   <= aac_pkg::CHG_NONE;
      conv_q     <= 1'b0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_idx)
          aac_pkg::REG_TPR:     tpr_q     <= pwdata[aac_pkg::CNT_W-1:0];
          aac_pkg::REG_LOW:     low_q     <= pwdata[aac_pkg::CNT_W-1:0];
          aac_pkg::REG_HIGH:    high_q    <= pwdata[aac_pkg::CNT_W-1:0];
          aac_pkg::REG_SHRINK:  shrink_q  <= pwdata[aac_pkg::FRAC_W-1:0];
          aac_pkg::REG_GROW:    grow_q    <= pwdata[aac_pkg::GROW_W-1:0];
          aac_pkg::REG_COOLING: cooling_q <= pwdata[aac_pkg::FRAC_W-1:0];
          aac_pkg::REG_FLOOR:   floor_q   <= pwdata[aac_pkg::FLOOR_W-1:0];
          aac_pkg::REG_LIMIT:   limit_q   <= pwdata[aac_pkg::CALL_W-1:0];
          default:              limit_q   <= limit_q;
        endcase
      end

      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tvalid_q && m_tready) begin
        m_tvalid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_tvalid) begin
            acc_q    <= 1'b0;
            done_q   <= 1'b0;
            change_q <= aac_pkg::CHG_NONE;
            conv_q   <= 1'b0;
            if (halt_q != aac_pkg::HALT_RUN) begin
              state_q <= ST_OUT;
            end else if (s_tuser == aac_pkg::REQ_LOAD) begin
              cur_q   <= s_tdata[aac_pkg::ENERGY_W-1:0];
              state_q <= ST_OUT;
            end else begin
              state_q <= ST_DELTA;
            end
          end
        end
        ST_DELTA: begin
          if (delta[aac_pkg::ENERGY_W]) begin
            acc_q   <= 1'b1;
            state_q <= ST_UPD;
          end else if (q_sat) begin
            state_q <= ST_EXP;
          end else begin
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_EXP;
          end
        end
        ST_EXP: begin
          if (mul_done) begin
            acc_q   <= exp_acc;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          if (acc_q) begin
            cur_q <= energy_q;
          end
          if (call_q != aac_pkg::CALL_MAX) begin
            call_q <= call_q + 1'b1;
          end
          if (round_end) begin
            done_q   <= 1'b1;
            change_q <= change_nx;
            conv_q   <= step_q < aac_pkg::STEP_W'(floor_q);
            trial_q  <= '0;
            succ_q   <= '0;
            state_q  <= ST_ADJ;
          end else begin
            trial_q <= trial_nx;
            succ_q  <= succ_nx;
            state_q <= ST_OUT;
          end
        end
        ST_ADJ: begin
          if (mul_done) begin
            case (change_q)
              aac_pkg::CHG_SHRINK: step_q <= prod[aac_pkg::STEP_W+15:16];
              aac_pkg::CHG_GROW: begin
                step_q <= (|grown[aac_pkg::STEP_W+1:aac_pkg::STEP_W]) ? '1
                                                                      : grown[aac_pkg::STEP_W-1:0];
              end
              default: begin
                temp_q <= prod[aac_pkg::TEMP_W+15:16];
                if (conv_q) begin
                  halt_q <= aac_pkg::HALT_CONV;
                end
              end
            endcase
            if (!(change_q == aac_pkg::CHG_NONE && conv_q) && call_q > limit_q) begin
              halt_q <= aac_pkg::HALT_FAIL;
            end
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_tvalid) begin
      energy_q <= s_tdata[aac_pkg::ENERGY_W-1:0];
      rand_q   <= s_tdata[aac_pkg::S_DATA_W-1:aac_pkg::ENERGY_W];
    end
    if (out_load) begin
      m_tdata_q <= {2'b00, temp_q, step_q, halt_q, change_q, done_q, acc_q};
    end
  end

  assign s_tready = (state_q == ST_IDLE);
  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = m_tdata_q;

endmodule

// ===== src/aac_div.sv =====
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module aac_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [aac_pkg::NUM_W-1:0]  num_i,
  input  logic [aac_pkg::TEMP_W-1:0] den_i,
  output logic                       done_o,
  output logic [aac_pkg::Q_W-1:0]    quot_o
);

  localparam int unsigned DSH_W = aac_pkg::TEMP_W + aac_pkg::Q_W - 1;

  logic                           busy_q;
  logic                           done_q;
  logic [aac_pkg::DIV_CNT_W-1:0]  cnt_q;
  logic [aac_pkg::NUM_W-1:0]      rem_q;
  logic [DSH_W-1:0]               dsh_q;
  logic [aac_pkg::Q_W-1:0]        quot_q;
  logic                           ge;

  assign ge = DSH_W'(rem_q) >= dsh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == aac_pkg::DIV_CNT_W'(aac_pkg::Q_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= num_i;
      dsh_q  <= {den_i, {(aac_pkg::Q_W - 1){1'b0}}};
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q[aac_pkg::NUM_W-1:0];
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[aac_pkg::Q_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ===== src/aac_mul.sv =====
// Shift-add multiplier, one multiplier bit per cycle, full-width product.
`timescale 1ns / 1ps
module aac_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [aac_pkg::MUL_W-1:0]    a_i,
  input  logic [aac_pkg::MUL_W-1:0]    b_i,
  output logic                         done_o,
  output logic [2*aac_pkg::MUL_W-1:0]  prod_o
);

  localparam int unsigned W = aac_pkg::MUL_W;

  logic                           busy_q;
  logic                           done_q;
  logic [aac_pkg::MUL_CNT_W-1:0]  cnt_q;
  logic [W-1:0]                   a_q;
  logic [W-1:0]                   b_q;
  logic [2*W-1:0]                 acc_q;
  logic [W:0]                     sum;

  assign sum = {1'b0, acc_q[2*W-1:W]} + (b_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == aac_pkg::MUL_CNT_W'(W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      b_q   <= b_q >> 1;
      acc_q <= {sum, acc_q[W-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the annealing acceptance controller: stream traffic, APB config.
`timescale 1ns / 1ps
module tb;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 160;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam logic [63:0] UNIT_Q60      = 64'd1 << 60;

  typedef struct packed {
    logic                       accepted;
    logic                       round_done;
    logic [aac_pkg::CODE_W-1:0] change;
    logic [aac_pkg::CODE_W-1:0] run;
    logic [aac_pkg::STEP_W-1:0] step;
    logic [aac_pkg::TEMP_W-1:0] temp;
  } result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_tvalid;
  logic                         s_tready;
  logic [aac_pkg::S_DATA_W-1:0] s_tdata;
  logic                         s_tuser;
  logic                         m_tvalid;
  logic                         m_tready;
  logic [aac_pkg::M_DATA_W-1:0] m_tdata;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [aac_pkg::APB_AW-1:0]   paddr;
  logic [aac_pkg::APB_DW-1:0]   pwdata;
  logic [aac_pkg::APB_DW-1:0]   prdata;
  logic                         pready;

  annealing_acceptance_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // register mirror
  logic [aac_pkg::CNT_W-1:0]   round_len;
  logic [aac_pkg::CNT_W-1:0]   low_limit;
  logic [aac_pkg::CNT_W-1:0]   high_limit;
  logic [aac_pkg::FRAC_W-1:0]  shrink_mul;
  logic [aac_pkg::GROW_W-1:0]  grow_mul;
  logic [aac_pkg::FRAC_W-1:0]  cool_mul;
  logic [aac_pkg::FLOOR_W-1:0] step_floor_cfg;
  logic [aac_pkg::CALL_W-1:0]  call_limit_cfg;

  // controller state mirror
  logic signed [63:0]          cur_energy;
  logic [aac_pkg::TEMP_W-1:0]  temp_q16;
  logic [aac_pkg::STEP_W-1:0]  step_q32;
  logic [aac_pkg::CNT_W-1:0]   trial_cnt;
  logic [aac_pkg::CNT_W-1:0]   win_cnt;
  logic [aac_pkg::CALL_W-1:0]  call_cnt;
  logic [aac_pkg::CODE_W-1:0]  halt_code;

  logic [15:0] metropolis_limit [0:4095];
  result_t     outcome_q [$];

  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_until_empty;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = 128'(a) * 128'(b);
    return 64'(p >> 60);
  endfunction

  // exp(-x) by forty terms of the series, Q0.60
  function automatic logic [63:0] exp_neg_q60(input logic [63:0] x);
    logic [63:0] sum;
    logic [63:0] term;
    sum  = UNIT_Q60;
    term = UNIT_Q60;
    for (int k = 1; k <= 40; k++) begin
      term = q60_mul(term, x) / 64'(k);
      sum  = (k % 2 == 1) ? sum - term : sum + term;
    end
    return sum;
  endfunction

  task automatic build_metropolis_table();
    logic [63:0] pow_e [0:15];
    logic [63:0] frac_e [0:255];
    logic [63:0] e1;
    logic [63:0] v;
    e1 = exp_neg_q60(UNIT_Q60);
    pow_e[0] = UNIT_Q60;
    for (int i = 1; i < 16; i++) pow_e[i] = q60_mul(pow_e[i-1], e1);
    for (int f = 0; f < 256; f++) frac_e[f] = exp_neg_q60(64'(f) << 52);
    for (int q = 0; q < 4096; q++) begin
      v = q60_mul(pow_e[q >> 8], frac_e[q & 255]);
      v = (v + (64'd1 << 43)) >> 44;
      metropolis_limit[q] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
    end
  endtask

  task automatic reset_model();
    round_len      = aac_pkg::TPR_RST;
    low_limit      = aac_pkg::LOW_RST;
    high_limit     = aac_pkg::HIGH_RST;
    shrink_mul     = aac_pkg::SHRINK_RST;
    grow_mul       = aac_pkg::GROW_RST;
    cool_mul       = aac_pkg::COOLING_RST;
    step_floor_cfg = aac_pkg::FLOOR_RST;
    call_limit_cfg = aac_pkg::LIMIT_RST;
    cur_energy     = '0;
    temp_q16       = aac_pkg::TEMP_RST;
    step_q32       = aac_pkg::STEP_RST;
    trial_cnt      = '0;
    win_cnt        = '0;
    call_cnt       = '0;
    halt_code      = aac_pkg::HALT_RUN;
  endtask

  function automatic result_t predict_outcome(input logic kind, input logic [31:0] energy_bits,
                                              input logic [15:0] rnd);
    result_t            r;
    logic signed [63:0] energy;
    logic signed [63:0] delta;
    logic [63:0]        q;
    logic [63:0]        prod;
    r      = '0;
    energy = {{32{energy_bits[31]}}, energy_bits};
    if (halt_code == aac_pkg::HALT_RUN) begin
      if (kind == aac_pkg::REQ_LOAD) begin
        cur_energy = energy;
      end else begin
        delta = energy - cur_energy;
        if (delta < 0) begin
          r.accepted = 1'b1;
        end else begin
          q = 64'd4095;
          if (temp_q16 != 0) begin
            q = {delta[55:0], 8'd0} / {32'd0, temp_q16};
            if (q > 64'd4095) q = 64'd4095;
          end
          r.accepted = (rnd < metropolis_limit[q[11:0]]);
        end
        if (r.accepted) cur_energy = energy;
        if (call_cnt != aac_pkg::CALL_MAX) call_cnt = call_cnt + 1'b1;
        trial_cnt = trial_cnt + 1'b1;
        win_cnt   = win_cnt + {{(aac_pkg::CNT_W-1){1'b0}}, r.accepted};
        if (trial_cnt >= round_len) begin
          r.round_done = 1'b1;
          if (win_cnt < low_limit) begin
            prod     = 64'(step_q32) * 64'(shrink_mul);
            step_q32 = prod[55:16];
            r.change = aac_pkg::CHG_SHRINK;
          end else if (win_cnt > high_limit) begin
            prod     = (64'(step_q32) * 64'(grow_mul)) >> 16;
            step_q32 = (prod > 64'hFF_FFFF_FFFF) ? '1 : prod[39:0];
            r.change = aac_pkg::CHG_GROW;
          end else begin
            prod     = 64'(temp_q16) * 64'(cool_mul);
            temp_q16 = prod[47:16];
            if (step_q32 < {8'd0, step_floor_cfg}) halt_code = aac_pkg::HALT_CONV;
          end
          if (halt_code == aac_pkg::HALT_RUN && call_cnt > call_limit_cfg) begin
            halt_code = aac_pkg::HALT_FAIL;
          end
          trial_cnt = '0;
          win_cnt   = '0;
        end
      end
    end
    r.run  = halt_code;
    r.step = step_q32;
    r.temp = temp_q16;
    return r;
  endfunction

  task automatic report_field(input string field, input logic [63:0] got,
                              input logic [63:0] want);
    if (got !== want) begin
      fail_count++;
      if (fail_count <= MAX_PRINTS) begin
        $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (outcome_q.size() == 0) begin
        report_field("result with no request", 64'd1, 64'd0);
      end else begin
        want = outcome_q.pop_front();
        report_field("accepted", 64'(m_tdata[0]), 64'(want.accepted));
        report_field("round_done", 64'(m_tdata[1]), 64'(want.round_done));
        report_field("step_change", 64'(m_tdata[3:2]), 64'(want.change));
        report_field("run_result", 64'(m_tdata[5:4]), 64'(want.run));
        report_field("step_now", 64'(m_tdata[45:6]), 64'(want.step));
        report_field("temp_now", 64'(m_tdata[77:46]), 64'(want.temp));
      end
    end
  end

  function automatic logic [31:0] reg_value(input logic [aac_pkg::REG_IDX_W-1:0] idx);
    case (idx)
      aac_pkg::REG_TPR:     return 32'(round_len);
      aac_pkg::REG_LOW:     return 32'(low_limit);
      aac_pkg::REG_HIGH:    return 32'(high_limit);
      aac_pkg::REG_SHRINK:  return 32'(shrink_mul);
      aac_pkg::REG_GROW:    return 32'(grow_mul);
      aac_pkg::REG_COOLING: return 32'(cool_mul);
      aac_pkg::REG_FLOOR:   return 32'(step_floor_cfg);
      default:              return 32'(call_limit_cfg);
    endcase
  endfunction

  // write, then read back
  task automatic write_reg(input logic [aac_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      aac_pkg::REG_TPR:     round_len      = value[aac_pkg::CNT_W-1:0];
      aac_pkg::REG_LOW:     low_limit      = value[aac_pkg::CNT_W-1:0];
      aac_pkg::REG_HIGH:    high_limit     = value[aac_pkg::CNT_W-1:0];
      aac_pkg::REG_SHRINK:  shrink_mul     = value[aac_pkg::FRAC_W-1:0];
      aac_pkg::REG_GROW:    grow_mul       = value[aac_pkg::GROW_W-1:0];
      aac_pkg::REG_COOLING: cool_mul       = value[aac_pkg::FRAC_W-1:0];
      aac_pkg::REG_FLOOR:   step_floor_cfg = value[aac_pkg::FLOOR_W-1:0];
      default:              call_limit_cfg = value[aac_pkg::CALL_W-1:0];
    endcase
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    report_field("register readback", 64'(prdata), 64'(reg_value(idx)));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_item(input logic kind, input logic [31:0] energy, input logic [15:0] rnd);
    @(negedge clk_i);
    if (hold_until_empty || $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
      while ((hold_until_empty && outcome_q.size() != 0) ||
             $urandom_range(99) < send_idle_pct) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rnd, energy};
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_tready);
    outcome_q.push_back(predict_outcome(kind, energy, rnd));
  endtask

  function automatic logic [31:0] clamp_energy(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  task automatic send_trial_at(input logic signed [63:0] delta, input logic [15:0] rnd);
    send_item(aac_pkg::REQ_TRIAL, clamp_energy(cur_energy + delta), rnd);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_tvalid <= 1'b0;
    while (outcome_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // reset settings: no round closes here
  task automatic test_request_basics();
    send_item(aac_pkg::REQ_TRIAL, 32'd0, 16'd0);
    send_item(aac_pkg::REQ_LOAD, 32'h7FFF_FFFF, 16'h1234);
    send_item(aac_pkg::REQ_TRIAL, 32'h8000_0000, 16'hFFFF);
    send_item(aac_pkg::REQ_TRIAL, 32'h7FFF_FFFF, 16'd0);
    send_trial_at(64'sd0, 16'hFFFF);
    send_trial_at(64'sd0, 16'hFFFE);
    send_trial_at(64'(temp_q16), metropolis_limit[256] - 1'b1);
    send_trial_at(64'(temp_q16), metropolis_limit[256]);
    send_item(aac_pkg::REQ_LOAD, 32'd0, 16'd0);
    wait_idle();
  endtask

  task automatic test_round_rules();
    write_reg(aac_pkg::REG_TPR, 32'd0);
    write_reg(aac_pkg::REG_LOW, 32'd0);
    write_reg(aac_pkg::REG_HIGH, 32'd0);
    write_reg(aac_pkg::REG_GROW, 32'h3FFFF);
    repeat (8) send_trial_at(-64'sd1, 16'hFFFF);
    wait_idle();
    write_reg(aac_pkg::REG_LOW, 32'd1);
    write_reg(aac_pkg::REG_SHRINK, 32'hFFFF);
    send_item(aac_pkg::REQ_TRIAL, 32'h7FFF_FFFF, 16'hFFFF);
    wait_idle();
    write_reg(aac_pkg::REG_HIGH, 32'd1023);
    send_trial_at(-64'sd1, 16'hFFFF);
    wait_idle();
    write_reg(aac_pkg::REG_HIGH, 32'd0);
    write_reg(aac_pkg::REG_GROW, 32'h10000);
    send_trial_at(-64'sd1, 16'h0);
    wait_idle();
  endtask

  task automatic test_long_round();
    write_reg(aac_pkg::REG_TPR, 32'd1023);
    write_reg(aac_pkg::REG_LOW, 32'd1023);
    repeat (3) send_item(aac_pkg::REQ_TRIAL, $urandom, 16'($urandom));
    wait_idle();
  endtask

  task automatic random_settings();
    int unsigned len;
    int unsigned lo;
    len = $urandom_range(1, 24);
    lo  = $urandom_range(0, len);
    write_reg(aac_pkg::REG_TPR, len);
    write_reg(aac_pkg::REG_LOW, lo);
    write_reg(aac_pkg::REG_HIGH, lo + $urandom_range(0, len));
    write_reg(aac_pkg::REG_SHRINK, $urandom_range(40000, 65535));
    write_reg(aac_pkg::REG_GROW, $urandom_range(65536, 80000));
    write_reg(aac_pkg::REG_COOLING, $urandom_range(62000, 65535));
    write_reg(aac_pkg::REG_FLOOR, 32'd0);
    write_reg(aac_pkg::REG_LIMIT, $urandom_range(32'h10_0000, 32'hFF_FFFF));
  endtask

  // mostly trials aimed across the acceptance curve, some noise and loads
  task automatic run_random(input int count);
    int unsigned        sel;
    int unsigned        target;
    logic signed [63:0] d;
    logic [15:0]        lim;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_item(aac_pkg::REQ_LOAD, $urandom, 16'($urandom));
      end else if (sel < 16) begin
        send_item(aac_pkg::REQ_TRIAL, $urandom, 16'($urandom));
      end else if (sel < 40) begin
        d = 64'($urandom_range(1, 1 << 20));
        send_trial_at(-d, 16'($urandom));
      end else begin
        target = $urandom_range(0, 4200);
        d      = $signed((64'(target) * 64'(temp_q16)) >> 8) + 64'($urandom_range(0, 3));
        lim    = metropolis_limit[(target > 4095) ? 4095 : target];
        send_trial_at(d, $urandom_range(1) ? 16'($urandom) :
                         16'(lim + $urandom_range(0, 4) - 2));
      end
    end
  endtask

  task automatic test_random_traffic();
    int unsigned idle_mix [4][2];
    idle_mix = '{'{0, 0}, '{52, 0}, '{0, 52}, '{24, 24}};
    for (int phase = 0; phase < 4; phase++) begin
      random_settings();
      if (phase == 2) write_reg(aac_pkg::REG_COOLING, 32'hFFFF);
      if (phase == 3) write_reg(aac_pkg::REG_LIMIT, 32'hFF_FFFF);
      send_idle_pct = idle_mix[phase][0];
      stall_pct     = idle_mix[phase][1];
      if (phase == 0) begin
        hold_until_empty = 1'b1;
        run_random(30);
        hold_until_empty = 1'b0;
        run_random(435);
      end else begin
        run_random(465);
      end
      wait_idle();
    end
    send_idle_pct = 0;
    stall_pct     = 0;
  endtask

  task automatic test_zero_temperature();
    write_reg(aac_pkg::REG_TPR, 32'd0);
    write_reg(aac_pkg::REG_LOW, 32'd0);
    write_reg(aac_pkg::REG_HIGH, 32'd1023);
    write_reg(aac_pkg::REG_COOLING, 32'd0);
    send_trial_at(-64'sd1, 16'hFFFF);
    send_trial_at(64'sd0, 16'd0);
    send_trial_at(-64'sd3, 16'hFFFF);
    send_trial_at(64'sd1000, 16'd0);
    wait_idle();
    write_reg(aac_pkg::REG_LOW, 32'd1023);
    write_reg(aac_pkg::REG_SHRINK, 32'd0);
    send_trial_at(64'sd1, 16'hFFFF);
    wait_idle();
  endtask

  // converge or fail, picked by the seed; both can only end the run
  task automatic test_halt();
    bit converge;
    converge = 1'($urandom_range(1));
    write_reg(aac_pkg::REG_LOW, 32'd0);
    write_reg(aac_pkg::REG_HIGH, 32'd1023);
    write_reg(aac_pkg::REG_FLOOR, 32'hFFFF_FFFF);
    if (!converge) write_reg(aac_pkg::REG_FLOOR, 32'd0);
    write_reg(aac_pkg::REG_LIMIT, 32'd0);
    send_trial_at(-64'sd1, 16'd0);
    repeat (6) send_item(1'($urandom), $urandom, 16'($urandom));
    wait_idle();
  endtask

  initial begin
    rst_ni           = 1'b0;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = 1'b0;
    m_tready         = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    fail_count       = 0;
    cycle_count      = 0;
    send_idle_pct    = 0;
    stall_pct        = 0;
    hold_until_empty = 1'b0;
    build_metropolis_table();
    reset_model();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_request_basics();
    test_round_rules();
    test_long_round();
    test_random_traffic();
    test_zero_temperature();
    test_halt();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
